// ===== rtl/core/slcd_pkg.sv =====
// Shared types, glyph table and digit placement tables for the segment LCD writer.
`default_nettype none
package slcd_pkg;

   localparam int RamBytes   = 14;
   localparam int Groups     = 8;
   localparam int Rows       = 6;
   localparam int GlyphCount = 37;
   localparam int QueueDepth = 2;

   // Item kinds as they arrive on the request channel
   localparam logic [1:0] KIND_PRINT     = 2'd0;
   localparam logic [1:0] KIND_CLEAR_COL = 2'd1;
   localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_FOLD     = 8'd32;
   localparam logic [7:0] LETTER_OFFSET = 8'd55;
   localparam logic [5:0] GLYPH_SPACE   = 6'd36;

   // Classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_IGNORE    = 2'd0,
      OP_WRITE     = 2'd1,
      OP_CLEAR_ALL = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  row;
      logic [15:0] glyph;
   } cmd_type;

   localparam logic [15:0] GLYPH_ROM [GlyphCount] = '{
      16'h00D7, 16'h0006, 16'h007D, 16'h006F, 16'h00AE, 16'h00EB, 16'h00FB, 16'h0046,
      16'h00FF, 16'h00EF, 16'h00FE, 16'h00BB, 16'h00D1, 16'h003F, 16'h00F9, 16'h00F8,
      16'h00F3, 16'h00BE, 16'h4441, 16'h0017, 16'h1198, 16'h0091, 16'h9096, 16'h8196,
      16'h00D7, 16'h00FC, 16'h00EE, 16'h01FC, 16'h00EB, 16'h4440, 16'h0097, 16'h9096,
      16'h2196, 16'hB100, 16'h9400, 16'h3041, 16'h0000
   };

   // RAM byte and bit offset of each 2-bit group, per digit row
   localparam logic [3:0] GROUP_BYTE [Rows][Groups] = '{
      '{4'd13, 4'd9, 4'd7, 4'd10, 4'd6, 4'd0, 4'd2, 4'd3},
      '{4'd13, 4'd9, 4'd7, 4'd10, 4'd6, 4'd0, 4'd2, 4'd3},
      '{4'd12, 4'd9, 4'd7, 4'd11, 4'd5, 4'd0, 4'd2, 4'd4},
      '{4'd12, 4'd9, 4'd7, 4'd11, 4'd5, 4'd0, 4'd2, 4'd4},
      '{4'd12, 4'd8, 4'd8, 4'd11, 4'd5, 4'd1, 4'd1, 4'd4},
      '{4'd12, 4'd8, 4'd8, 4'd11, 4'd5, 4'd1, 4'd1, 4'd4}
   };

   localparam logic [2:0] GROUP_SHIFT [Rows][Groups] = '{
      '{3'd2, 3'd6, 3'd0, 3'd4, 3'd2, 3'd0, 3'd6, 3'd4},
      '{3'd0, 3'd4, 3'd2, 3'd6, 3'd0, 3'd2, 3'd4, 3'd6},
      '{3'd6, 3'd2, 3'd4, 3'd0, 3'd6, 3'd4, 3'd2, 3'd0},
      '{3'd4, 3'd0, 3'd6, 3'd2, 3'd4, 3'd6, 3'd0, 3'd2},
      '{3'd2, 3'd6, 3'd0, 3'd4, 3'd2, 3'd0, 3'd6, 3'd4},
      '{3'd0, 3'd4, 3'd2, 3'd6, 3'd0, 3'd2, 3'd4, 3'd6}
   };

endpackage
`default_nettype wire

// ===== rtl/core/slcd_front.sv =====
// Front end: accepts request items and classifies them into back-end commands.
`default_nettype none
module slcd_front
   import slcd_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_char_code,
   input  wire logic [2:0] req_position,
   input  wire logic       q_full,
   output logic            push,
   output cmd_type         push_cmd
);

   logic [7:0] folded;
   logic [7:0] gidx_wide;
   logic [5:0] gidx;
   logic       char_ok;
   logic       pos_ok;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Character to glyph number
   always_comb begin
      folded    = req_char_code;
      gidx_wide = '0;
      char_ok   = 1'b1;
      if (req_char_code >= CHAR_LOWER_A && req_char_code <= CHAR_LOWER_Z) begin
         folded = req_char_code - CASE_FOLD;
      end
      if (req_char_code >= CHAR_ZERO && req_char_code <= CHAR_NINE) begin
         gidx_wide = req_char_code - CHAR_ZERO;
      end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
         gidx_wide = folded - LETTER_OFFSET;
      end else if (req_char_code == CHAR_SPACE) begin
         gidx_wide = 8'(GLYPH_SPACE);
      end else begin
         char_ok = 1'b0;
      end
      gidx = gidx_wide[5:0];
   end

   assign pos_ok = (req_position >= 3'd1) && (req_position <= 3'd6);

   // Classify
   always_comb begin
      push_cmd.op    = OP_IGNORE;
      push_cmd.row   = req_position - 3'd1;
      push_cmd.glyph = '0;
      unique case (req_kind)
         KIND_CLEAR_ALL: push_cmd.op = OP_CLEAR_ALL;
         KIND_PRINT: begin
            if (pos_ok && char_ok) begin
               push_cmd.op    = OP_WRITE;
               push_cmd.glyph = GLYPH_ROM[gidx];
            end
         end
         KIND_CLEAR_COL: begin
            if (pos_ok) push_cmd.op = OP_WRITE;
         end
         default: push_cmd.op = OP_IGNORE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_queue.sv =====
// Two-entry command queue between front and back ends.
`default_nettype none
module slcd_queue
   import slcd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head
);

   cmd_type    slot_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(QueueDepth));
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_back.sv =====
// Back end: segment RAM update and in-order reporting of touched bytes.
`default_nettype none
module slcd_back
   import slcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_not_empty,
   input  cmd_type         q_head,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_ram_index,
   output logic [7:0]      rsp_ram_value,
   output logic            rsp_ignored,
   output logic            rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         ram_ff [RamBytes];
   logic [7:0]         ram_in [RamBytes];
   logic [RamBytes-1:0] touched_ff, touched_in;
   logic [RamBytes-1:0] wr_mask;
   logic [RamBytes-1:0] rest;
   logic [7:0]         wr_val [RamBytes];
   logic [3:0]         idx_ff, idx_in;
   logic               out_free;
   logic               load_out;
   logic [3:0]         out_idx;
   logic [7:0]         out_val;
   logic               out_ign;
   logic               out_last;
   logic               rsp_valid_ff;
   logic [3:0]         rsp_index_ff;
   logic [7:0]         rsp_value_ff;
   logic               rsp_ignored_ff;
   logic               rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Scatter of the eight glyph groups into the selected row's bytes
   always_comb begin
      for (int j = 0; j < RamBytes; j++) begin
         wr_val[j]  = ram_ff[j];
         wr_mask[j] = 1'b0;
         for (int i = 0; i < Groups; i++) begin
            if (GROUP_BYTE[q_head.row][i] == 4'(j)) begin
               wr_val[j] = (wr_val[j] & ~(8'd3 << GROUP_SHIFT[q_head.row][i]))
                         | ({6'd0, q_head.glyph[15-2*i -: 2]}
                            << GROUP_SHIFT[q_head.row][i]);
               wr_mask[j] = 1'b1;
            end
         end
      end
   end

   assign rest = touched_ff & ~(RamBytes'(1) << idx_ff);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      touched_in = touched_ff;
      idx_in     = idx_ff;
      ram_in     = ram_ff;
      pop        = 1'b0;
      load_out   = 1'b0;
      out_idx    = idx_ff;
      out_val    = ram_ff[idx_ff];
      out_ign    = 1'b0;
      out_last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               case (q_head.op)
                  OP_WRITE: begin
                     pop        = 1'b1;
                     ram_in     = wr_val;
                     touched_in = wr_mask;
                     idx_in     = '0;
                     state_in   = ST_SCAN;
                  end
                  OP_CLEAR_ALL: begin
                     pop = 1'b1;
                     for (int j = 0; j < RamBytes; j++) ram_in[j] = '0;
                     touched_in = '1;
                     idx_in     = '0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        load_out = 1'b1;
                        out_idx  = '0;
                        out_val  = '0;
                        out_ign  = 1'b1;
                        out_last = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!touched_ff[idx_ff]) begin
               idx_in = idx_ff + 4'd1;
            end else if (out_free) begin
               load_out   = 1'b1;
               out_last   = (rest == '0);
               touched_in = rest;
               idx_in     = idx_ff + 4'd1;
               if (rest == '0) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         touched_ff <= '0;
         idx_ff     <= '0;
         for (int j = 0; j < RamBytes; j++) ram_ff[j] <= '0;
      end else begin
         state_ff   <= state_in;
         touched_ff <= touched_in;
         idx_ff     <= idx_in;
         ram_ff     <= ram_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_index_ff   <= out_idx;
         rsp_value_ff   <= out_val;
         rsp_ignored_ff <= out_ign;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ram_index = rsp_index_ff;
   assign rsp_ram_value = rsp_value_ff;
   assign rsp_ignored   = rsp_ignored_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/segment_lcd_char_writer_unit.sv =====
// Ignored items are answered from the idle state; print and clear items update the RAM
// as they are dequeued, and the touched bytes are then reported in ascending order.
// Print and clear items hold the back end for one dequeue step plus one scan step per RAM
// byte up to the highest touched; ignored items take the dequeue step. A stalled output holds both.
// A two-entry command queue lets requests be taken while the back end works.
// Synchronous active-high reset zeroes the segment RAM and empties queue and output.
`default_nettype none
module segment_lcd_char_writer_unit
   import slcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_char_code,
   input  wire logic [2:0] req_position,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_ram_index,
   output logic [7:0]      rsp_ram_value,
   output logic            rsp_ignored,
   output logic            rsp_last
);

   logic    q_full;
   logic    q_not_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;

   slcd_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .req_position  (req_position),
      .q_full        (q_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   slcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   slcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ram_index (rsp_ram_index),
      .rsp_ram_value (rsp_ram_value),
      .rsp_ignored   (rsp_ignored),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/core/slcd_checker.sv =====
// Port-level checker for the segment LCD writer, bound to the top level.
`default_nettype none
module slcd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_ram_index,
   input wire logic [7:0] rsp_ram_value,
   input wire logic       rsp_ignored,
   input wire logic       rsp_last
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // An ignored result is always marked as the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_last)
      else $error("ignored result without last mark");

   // Ignored results carry zero index and value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_ram_index == 4'd0 && rsp_ram_value == 8'd0)
      else $error("ignored result carries data");

   // Reported bytes stay within the segment RAM
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ram_index <= 4'd13)
      else $error("RAM index out of range");

   // Nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind segment_lcd_char_writer_unit slcd_checker u_slcd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_ram_index (rsp_ram_index),
   .rsp_ram_value (rsp_ram_value),
   .rsp_ignored   (rsp_ignored),
   .rsp_last      (rsp_last)
);
`default_nettype wire
